### hdl/sira_pkg.sv
package sira_pkg;

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 7'h39;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 7'h7a;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2d;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DECIMAL_LIMIT) begin
      return dx + CH_ZERO;
    end
    return dx - {1'b0, DECIMAL_LIMIT} + CH_LOWER_A;
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end
    if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

endpackage

### hdl/sira_ram.sv
module sira_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/sira_div.sv
// Restoring divider, one dividend bit per cycle; remainder stays below the radix.
module sira_div #(
  parameter int W = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [W-1:0]                        dividend,
  input  logic [sira_pkg::RADIX_W-1:0]        base,
  output sira_pkg::div_stat_t                 stat,
  output logic [W-1:0]                        quotient,
  output logic [sira_pkg::DIGIT_W-1:0]        remainder
);

  localparam int CNT_W = $clog2(W);

  logic [CNT_W-1:0]                 bit_cnt;
  logic                             busy;
  logic                             done;
  logic [sira_pkg::RADIX_W-1:0]     base_q;
  logic [sira_pkg::DIGIT_W:0]       trial;
  logic                             fits;

  assign trial = {remainder, quotient[W-1]};
  assign fits  = trial >= {1'b0, base_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
      end else if (busy) begin
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      quotient  <= dividend;
      remainder <= '0;
      base_q    <= base;
    end else if (busy) begin
      quotient <= {quotient[W-2:0], fits};
      if (fits) begin
        remainder <= sira_pkg::DIGIT_W'(trial - {1'b0, base_q});
      end else begin
        remainder <= trial[sira_pkg::DIGIT_W-1:0];
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### hdl/signed_integer_to_radix_ascii_top.sv
// Order: each digit takes a bit-serial division (ST_START, ST_DIV), then the sign state (ST_SIGN),
//   then a read and an emit per digit (ST_READ, ST_EMIT), held by any output stall; '-' follows the division.
// Flow: one number at a time; the next item is taken from the cycle after the last char is
//   loaded.
// Reset (rst, synchronous, active high): sequencer idle, no item pending,
//   radix back to 10. The digit RAM keeps whatever it held.
module signed_integer_to_radix_ascii_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // config: radix register
  input  logic                            cfg_we,
  input  logic [sira_pkg::RADIX_W-1:0]    cfg_data,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata,   // [VALUE_BITS-1:0] value, rest zero
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [6:0] text_char, [7] zero
  output logic                            m_tlast    // last_char
);

  localparam int AW     = $clog2(VALUE_BITS);
  localparam int DCNT_W = $clog2(VALUE_BITS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_SIGN  = 6'b001000,
    ST_READ  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t                          state;
  logic [sira_pkg::RADIX_W-1:0]    radix;
  logic [sira_pkg::RADIX_W-1:0]    base;
  logic [VALUE_BITS-1:0]           mag;
  logic                            neg;
  logic [DCNT_W-1:0]               cnt;
  logic [DCNT_W-1:0]               cnt_dec;
  logic [sira_pkg::CHAR_W-1:0]     out_char;

  logic signed [VALUE_BITS-1:0]    value_in;
  logic                            in_acc;
  logic                            out_free;
  logic                            out_load;

  sira_pkg::div_stat_t             div_stat;
  logic [VALUE_BITS-1:0]           div_quot;
  logic [sira_pkg::DIGIT_W-1:0]    div_rem;

  logic                            ram_we;
  logic                            ram_re;
  logic [sira_pkg::DIGIT_W-1:0]    ram_rdata;

  assign value_in = s_tdata[VALUE_BITS-1:0];
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  // output register can take a new char when empty or being drained
  assign out_free = !m_tvalid || m_tready;
  // a char (sign or digit) enters the output register this cycle
  assign out_load = ((state == ST_SIGN) && neg && out_free) ||
                    ((state == ST_EMIT) && out_free);
  assign cnt_dec  = cnt - 1'b1;

  // digits land LSD first at cnt, read back MSD first
  assign ram_we = (state == ST_DIV) && div_stat.done;
  assign ram_re = (state == ST_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= sira_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_data;
    end
  end

  sira_div #(.W(VALUE_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     ((state == ST_START) && !div_stat.busy),
    .dividend  (mag),
    .base      (base),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  sira_ram #(.WIDTH(sira_pkg::DIGIT_W), .DEPTH(VALUE_BITS)) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[AW-1:0]),
    .wdata (div_rem),
    .re    (ram_re),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            cnt   <= '0;
            state <= ST_START;
          end
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            cnt <= cnt + 1'b1;
            // stop on zero quotient; the digit cap never binds for radix >= 2
            if (div_quot == '0 || cnt == DCNT_W'(VALUE_BITS - 1)) begin
              state <= ST_SIGN;
            end else begin
              state <= ST_START;
            end
          end
        end
        ST_SIGN: begin
          if (!neg || out_free) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          cnt   <= cnt_dec;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= (cnt == '0) ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      neg  <= value_in[VALUE_BITS-1];
      base <= sira_pkg::clamp_radix(radix);
      mag  <= value_in[VALUE_BITS-1] ? $unsigned(-value_in) : $unsigned(value_in);
    end else if (state == ST_DIV && div_stat.done) begin
      mag <= div_quot;
    end
    if (state == ST_SIGN && neg && out_free) begin
      out_char <= sira_pkg::CH_MINUS;
      m_tlast  <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_char <= sira_pkg::digit_char(ram_rdata);
      m_tlast  <= (cnt == '0);
    end
  end

  assign m_tdata = {1'b0, out_char};

endmodule

### hdl/sira_chk.sv
module sira_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // reset leaves the block ready and empty
  a_reset: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

  // one number at a time: no second item right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // chars are '-', a decimal digit or a lowercase letter
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:0] == sira_pkg::CH_MINUS)
      || (m_tdata[6:0] >= sira_pkg::CH_ZERO && m_tdata[6:0] <= sira_pkg::CH_NINE)
      || (m_tdata[6:0] >= sira_pkg::CH_LOWER_A && m_tdata[6:0] <= sira_pkg::CH_LOWER_Z))
    else $error("bad char");

  // a sign never ends a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6:0] == sira_pkg::CH_MINUS |-> !m_tlast)
    else $error("sign flagged last");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled item changed");

endmodule

bind signed_integer_to_radix_ascii_top sira_chk u_sira_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int VALUE_BITS  = 32;
  localparam int TDATA_W     = ((VALUE_BITS + 7) / 8) * 8;
  localparam int RADIX_W     = sira_pkg::RADIX_W;
  localparam int DIGIT_W     = sira_pkg::DIGIT_W;
  localparam int CHAR_W      = sira_pkg::CHAR_W;
  localparam int RANDOM_ITEMS = 240;
  // quiet-cycle limit: a base-2 number runs its whole division with no handshake
  // at all; the limit leaves ample room for that plus sender gaps and receiver stalls
  localparam int QUIET_LIMIT = 20000;
  localparam int TAIL_CYCLES = 60;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               cfg_we   = 1'b0;
  logic [RADIX_W-1:0] cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata  = '0;    // [31:0] value
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;          // [6:0] text_char, [7] zero
  logic               m_tlast;          // last_char

  signed_integer_to_radix_ascii_top #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
  } glyph_t;

  // Holds the current radix and the characters still owed by the block.
  class radix_text_scoreboard;
    logic [RADIX_W-1:0] radix;
    glyph_t             owed[$];
    int unsigned        values_seen;
    int unsigned        chars_checked;
    int unsigned        radix_writes;
    int unsigned        mismatches;

    function new();
      radix = sira_pkg::RADIX_RESET;
    endfunction

    function void set_radix(input logic [RADIX_W-1:0] r);
      radix = r;
      radix_writes++;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function void flag(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    // Spell the value out in the current base, most significant digit first.
    function void note_value(input logic [VALUE_BITS-1:0] value);
      logic [RADIX_W-1:0]    base;
      logic [VALUE_BITS-1:0] mag;
      logic [DIGIT_W-1:0]    digits[VALUE_BITS];
      logic [CHAR_W-1:0]     ch;
      int                    n;
      base = (radix < sira_pkg::RADIX_MIN) ? sira_pkg::RADIX_MIN :
             (radix > sira_pkg::RADIX_MAX) ? sira_pkg::RADIX_MAX : radix;
      // unsigned negate: the most negative value keeps its magnitude 2^31
      mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
      n = 0;
      do begin
        digits[n] = DIGIT_W'(mag % base);
        mag = mag / base;
        n++;
      end while (mag != 0 && n < VALUE_BITS);
      if (value[VALUE_BITS-1]) begin
        owed.push_back('{text_char: sira_pkg::CH_MINUS, last_char: 1'b0});
      end
      for (int i = n - 1; i >= 0; i--) begin
        if (digits[i] < sira_pkg::DECIMAL_LIMIT) begin
          ch = sira_pkg::CH_ZERO + CHAR_W'(digits[i]);
        end else begin
          ch = sira_pkg::CH_LOWER_A + CHAR_W'(digits[i])
               - CHAR_W'(sira_pkg::DECIMAL_LIMIT);
        end
        owed.push_back('{text_char: ch, last_char: (i == 0)});
      end
      values_seen++;
    endfunction

    function void check_char(input logic [CHAR_W-1:0] ch, input logic last);
      glyph_t want;
      chars_checked++;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected char 0x%h ('%c') last=%0b", ch, ch, last));
        return;
      end
      want = owed.pop_front();
      if (want.text_char !== ch) begin
        flag($sformatf("text_char expected 0x%h ('%c'), got 0x%h ('%c')",
                       want.text_char, want.text_char, ch, ch));
      end
      if (want.last_char !== last) begin
        flag($sformatf("last_char expected %0b, got %0b after '%c'",
                       want.last_char, last, want.text_char));
      end
    endfunction
  endclass

  radix_text_scoreboard board = new();

  int unsigned burst_left = 0;
  int unsigned quiet      = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: ready follows a rotating 16-bit pattern, reloaded now and then.
  // Bit 0 is forced so the pattern always holds a set bit and the receiver never stalls for good.
  logic [15:0] ready_pattern = 16'hffff;
  int unsigned pattern_age   = 0;

  always @(posedge clk) begin
    if (pattern_age == 255) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= 16'hffff;                       // no stalls
        1: ready_pattern <= 16'($urandom) | 16'h0001;
        2: ready_pattern <= 16'($urandom | $urandom) | 16'h0001;
        default: ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
      endcase
      pattern_age <= 0;
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      pattern_age   <= pattern_age + 1;
    end
    m_tready <= ready_pattern[0];
  end

  // Result check: sampled at the edge, before any update of this step lands.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_char(m_tdata[CHAR_W-1:0], m_tlast);
    end
  end

  // Watchdog: a long stretch with no handshake on either side means a hang.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake", quiet);
      $display("tb: failure");
      $finish;
    end
  end

  // Hold the item until the block takes it; valid stays up for a following item.
  task automatic push_value(input logic [VALUE_BITS-1:0] v);
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'(v);
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    board.note_value(v);
  endtask

  task automatic sender_gap(input int unsigned cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending and wait until every owed character came back.
  // It always waits for the clock before returning, so valid is never dropped and raised in one step.
  task automatic drain();
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (board.pending() != 0);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    cfg_we   <= 1'b0;
    board.set_radix(r);
  endtask

  // Bursts of random length; gaps between them, sometimes long idle-free runs.
  task automatic pace();
    if (burst_left == 0) begin
      sender_gap($urandom_range(1, 16));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  // A power of the base, nudged by one either way, sometimes negated.
  function automatic logic [VALUE_BITS-1:0] near_power(input int unsigned base);
    longint p;
    int unsigned k;
    p = 1;
    k = $urandom_range(1, 31);
    repeat (k) begin
      if (p * base <= 64'h8000_0000) begin
        p = p * base;
      end
    end
    p = p + $urandom_range(0, 2) - 1;
    if ($urandom_range(0, 1) == 1) begin
      p = -p;
    end
    return p[VALUE_BITS-1:0];
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value(input logic [RADIX_W-1:0] r);
    int unsigned base;
    base = (r < sira_pkg::RADIX_MIN) ? sira_pkg::RADIX_MIN :
           (r > sira_pkg::RADIX_MAX) ? sira_pkg::RADIX_MAX : r;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3:       return $urandom_range(0, 40);
      4, 5:    return near_power(base);
      6:       return 32'h8000_0000 + $urandom_range(0, 3);
      7:       return 32'h7fff_ffff - $urandom_range(0, 3);
      8:       return -$urandom_range(1, 1000);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    logic [RADIX_W-1:0] r;
    int unsigned        left;
    int unsigned        n;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: radix still at its reset value of ten.
    push_value(32'd0);
    push_value(32'hffff_ffff);             // -1
    push_value(32'h7fff_ffff);             // largest positive
    push_value(32'h8000_0000);             // most negative, magnitude 2^31
    push_value(32'd1234567890);            // every decimal digit

    // Base 36: the top letter 'z' and a carry into two digits.
    write_radix(6'd36);
    push_value(32'd35);
    push_value(32'd36);
    push_value(32'h8000_0000);
    push_value(32'h7fff_ffff);

    // Base 2: longest text (sign plus 32 digits) and alternating bit patterns.
    write_radix(6'd2);
    push_value(32'h8000_0000);
    push_value(32'h5555_5555);
    push_value(32'haaaa_aaaa);

    // Radix outside 2..36 saturates to the nearest legal base.
    write_radix(6'd0);
    push_value(32'd5);
    write_radix(6'd1);
    push_value(32'hffff_fffd);
    write_radix(6'd37);
    push_value(32'd36);
    write_radix(6'd63);
    push_value(32'd35);
    push_value(-32'sd1295);

    write_radix(6'd16);
    push_value(32'hdead_beef);
    push_value(32'h0123_4567);
    push_value(32'h89ab_cdef);

    // Random phases, each under its own radix setting.
    left = RANDOM_ITEMS;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0:       r = 6'd2;
        1:       r = 6'd36;
        2:       r = RADIX_W'($urandom_range(0, 1));
        3:       r = RADIX_W'($urandom_range(37, 63));
        default: r = RADIX_W'($urandom_range(2, 36));
      endcase
      write_radix(r);
      burst_left = 0;
      n = $urandom_range(10, 40);
      if (n > left) begin
        n = left;
      end
      repeat (n) begin
        pace();
        if ($urandom_range(0, 24) == 0) begin
          drain();                         // let the block run completely dry
          burst_left = 0;
        end
        push_value(pick_value(r));
      end
      left -= n;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);   // catch any stray trailing characters

    if (board.pending() != 0) begin
      board.flag($sformatf("%0d characters never arrived", board.pending()));
    end
    $display("summary: %0d values converted under %0d radix writes, %0d characters checked",
             board.values_seen, board.radix_writes, board.chars_checked);
    $display("summary: %0d mismatches", board.mismatches);
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/sira_pkg.sv
hdl/sira_ram.sv
hdl/sira_div.sv
hdl/signed_integer_to_radix_ascii_top.sv
hdl/sira_chk.sv
verif/testbench.sv
